>>> hdl/uvs_pkg.sv
// Shared types, constants and arithmetic helpers for the UV sphere vertex and index unit.
// No dependencies; imported by uv_sphere_vertex_index_generator_unit.
`default_nettype none

package uvs_pkg;

    localparam int COUNT_BITS  = 8;
    localparam int COORD_BITS  = 16;
    localparam int INDEX_BITS  = 16;
    localparam int RADIUS_BITS = 15;
    localparam int PHASE_BITS  = 16;

    // Restoring divider: segment dividend is seg*2^17 + S, the widest one
    localparam int DIV_W  = COUNT_BITS + PHASE_BITS + 1;
    localparam int DIVR_W = COUNT_BITS + 1;

    localparam int CORDIC_STEPS = 16;
    localparam int CW           = PHASE_BITS + 2;
    localparam int CORDIC_START = 19899;
    localparam int Q15_MAX      = 32767;

    // Pipeline map
    localparam int ST_FOLD = DIV_W;
    localparam int ST_CORD = ST_FOLD + 1;
    localparam int ST_POST = ST_CORD + CORDIC_STEPS;
    localparam int ST_MUL1 = ST_POST + 1;
    localparam int ST_MUL2 = ST_MUL1 + 1;
    localparam int ST_OUT  = ST_MUL2 + 1;
    localparam int NST     = ST_OUT + 1;

    localparam int CFG_IDX_BITS = 2;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RADIUS  = 2'd0,
        CFG_RINGS   = 2'd1,
        CFG_SEGS    = 2'd2,
        CFG_UNUSED  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic                 flip;
        logic signed [CW-1:0] z;
    } fold_t;

    typedef struct packed {
        logic              q;
        logic [DIVR_W-1:0] rem;
    } div_t;

    function automatic logic signed [CW-1:0] atan_phase(input int i);
        logic signed [CW-1:0] a;
        case (i)
            0:       a = CW'(8192);
            1:       a = CW'(4836);
            2:       a = CW'(2555);
            3:       a = CW'(1297);
            4:       a = CW'(651);
            5:       a = CW'(326);
            6:       a = CW'(163);
            7:       a = CW'(81);
            8:       a = CW'(41);
            9:       a = CW'(20);
            10:      a = CW'(10);
            11:      a = CW'(5);
            12:      a = CW'(3);
            13:      a = CW'(1);
            14:      a = CW'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

    // One restoring step: shift in one dividend bit, subtract if it fits
    function automatic div_t div_step(input logic [DIVR_W-1:0] rem, input logic nbit,
                                      input logic [DIVR_W-1:0] d);
        logic [DIVR_W:0] t;
        div_t            r;
        t = {rem, nbit};
        if (t >= {1'b0, d})
        begin
            r.q   = 1'b1;
            r.rem = DIVR_W'(t - {1'b0, d});
        end
        else
        begin
            r.q   = 1'b0;
            r.rem = t[DIVR_W-1:0];
        end
        return r;
    endfunction

    // Fold the phase into [-1/4, 1/4) turn
    function automatic fold_t fold(input logic [PHASE_BITS-1:0] p);
        fold_t f;
        if (p >= 16'd16384 && p < 16'd49152)
        begin
            f.flip = 1'b1;
            f.z    = $signed({2'b00, p}) - CW'(32768);
        end
        else if (p >= 16'd49152)
        begin
            f.flip = 1'b0;
            f.z    = $signed({2'b00, p}) - CW'(65536);
        end
        else
        begin
            f.flip = 1'b0;
            f.z    = $signed({2'b00, p});
        end
        return f;
    endfunction

    function automatic cordic_t cordic_step(input cordic_t c, input int i);
        cordic_t              n;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        dx = c.y >>> i;
        dy = c.x >>> i;
        if (!c.z[CW-1])
        begin
            n.x = c.x - dx;
            n.y = c.y + dy;
            n.z = c.z - atan_phase(i);
        end
        else
        begin
            n.x = c.x + dx;
            n.y = c.y - dy;
            n.z = c.z + atan_phase(i);
        end
        return n;
    endfunction

    // Negate for the folded half, then clamp to +-32767
    function automatic logic signed [15:0] finish_q15(input logic signed [CW-1:0] v,
                                                      input logic flip);
        logic signed [CW-1:0] t;
        t = flip ? -v : v;
        if (t > CW'(Q15_MAX))
            return 16'sd32767;
        else if (t < -CW'(Q15_MAX))
            return -16'sd32767;
        else
            return t[15:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sd1 <<< (COORD_BITS - 1);
        hi = hi - 50'sd1;
        lo = -hi - 50'sd1;
        if (v > hi)
            return hi[COORD_BITS-1:0];
        else if (v < lo)
            return lo[COORD_BITS-1:0];
        else
            return v[COORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/uv_sphere_vertex_index_generator_unit.sv
// UV sphere vertex and triangle index unit, one grid point per word.
// Depends on uvs_pkg (constants, divider/CORDIC step functions).
`default_nettype none

// Usage
//   s_* channel: one grid point per word, tdata = {segment_number, ring_number}.
//   m_* channel: one result word per input word, in order. tdata carries
//   pos_x, pos_y, pos_z and the six triangle indices; tuser carries
//   indices_valid and bad_point.
//   cfg_we/cfg_index/cfg_data: write radius (0), ring_count (1),
//   segment_count (2) while no words are in flight.
// Pipeline and throughput
//   Between input accept and output valid lie 25 restoring divider steps
//   that turn the grid position into a phase (one quotient bit a stage),
//   one fold stage, 16 CORDIC rotation stages, one clamp stage, two
//   multiplier stages and the output register. A new word enters every
//   cycle unless the output stalls; divider and CORDIC set the depth.
// Reset
//   Clears all stage valid bits and loads radius 256, 16 rings, 16 segments.
// Stall
//   When the output word is held by m_tready low, the whole pipeline holds
//   and s_tready drops; bubbles inside the pipe are closed only by advance.
module uv_sphere_vertex_index_generator_unit
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [7:0] ring_number, [15:8] segment_number
    input  wire logic [2*uvs_pkg::COUNT_BITS-1:0] s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [63:48] tri_a0,
    // [79:64] tri_a1, [95:80] tri_a2, [111:96] tri_b0, [127:112] tri_b1,
    // [143:128] tri_b2
    output logic [143:0]                          m_tdata,
    // [0] indices_valid, [1] bad_point
    output logic [1:0]                            m_tuser,
    input  wire logic                             cfg_we,
    input  wire logic [uvs_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [uvs_pkg::RADIUS_BITS-1:0]  cfg_data
);
    import uvs_pkg::*;

    localparam int TAG_W = 2 * COUNT_BITS;

    logic [RADIUS_BITS-1:0] radius_reg;
    logic [COUNT_BITS-1:0]  rings_reg;
    logic [COUNT_BITS-1:0]  segs_reg;

    logic             en;
    logic             valid_reg [0:NST-1];
    logic [TAG_W-1:0] tag_reg   [0:NST-1];

    // divider stage registers, ring (r*) and segment (s*)
    logic [DIV_W-1:0]      rn_reg [0:DIV_W-1];
    logic [DIVR_W-1:0]     rr_reg [0:DIV_W-1];
    logic [PHASE_BITS-1:0] rq_reg [0:DIV_W-1];
    logic [DIV_W-1:0]      sn_reg [0:DIV_W-1];
    logic [DIVR_W-1:0]     sr_reg [0:DIV_W-1];
    logic [PHASE_BITS-1:0] sq_reg [0:DIV_W-1];

    fold_t   rfold_reg;
    fold_t   sfold_reg;
    cordic_t rc_reg    [0:CORDIC_STEPS-1];
    cordic_t sc_reg    [0:CORDIC_STEPS-1];
    logic    rflip_reg [0:CORDIC_STEPS-1];
    logic    sflip_reg [0:CORDIC_STEPS-1];

    logic signed [15:0] sin_r_reg;
    logic signed [15:0] cos_r_reg;
    logic signed [15:0] sin_s_reg;
    logic signed [15:0] cos_s_reg;
    logic signed [15:0] sin_s1_reg;
    logic signed [15:0] cos_s1_reg;
    logic signed [31:0] r0_reg;
    logic signed [31:0] ycr_reg;
    logic signed [31:0] ycr2_reg;
    logic signed [47:0] px_reg;
    logic signed [47:0] pz_reg;

    logic [143:0] data_reg;
    logic [1:0]   user_reg;

    logic [COUNT_BITS-1:0] rd;
    logic [COUNT_BITS-1:0] sd;
    logic [DIVR_W-1:0]     rdiv;
    logic [DIVR_W-1:0]     sdiv;
    logic [DIV_W-1:0]      rn_in;
    logic [DIV_W-1:0]      sn_in;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_BITS'(256);
            rings_reg  <= COUNT_BITS'(16);
            segs_reg   <= COUNT_BITS'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_RADIUS: radius_reg <= cfg_data;
                CFG_RINGS:  rings_reg  <= cfg_data[COUNT_BITS-1:0];
                CFG_SEGS:   segs_reg   <= cfg_data[COUNT_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // advance whenever the output register is empty or being taken
    assign en       = !valid_reg[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[NST-1];
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

    // a zero count divides as one
    assign rd    = (rings_reg == '0) ? COUNT_BITS'(1) : rings_reg;
    assign sd    = (segs_reg == '0) ? COUNT_BITS'(1) : segs_reg;
    assign rdiv  = {rd, 1'b0};
    assign sdiv  = {sd, 1'b0};
    assign rn_in = {1'b0, s_tdata[COUNT_BITS-1:0], {PHASE_BITS{1'b0}}} + DIV_W'(rd);
    assign sn_in = {s_tdata[TAG_W-1:COUNT_BITS], {(PHASE_BITS+1){1'b0}}} + DIV_W'(sd);

    // valid bits and grid position travel along every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= s_tvalid;
            for (int k = 1; k < NST; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= s_tdata;
            for (int k = 1; k < NST; k++)
                tag_reg[k] <= tag_reg[k-1];
        end
    end

    // phase = floor((n*2^16 + C) / 2C) for rings, floor((n*2^17 + C) / 2C) for segments, one quotient bit per stage
    genvar g;
    generate
        for (g = 0; g < DIV_W; g++)
        begin : g_div
            logic [DIV_W-1:0]      rn_i;
            logic [DIVR_W-1:0]     rr_i;
            logic [PHASE_BITS-1:0] rq_i;
            logic [DIV_W-1:0]      sn_i;
            logic [DIVR_W-1:0]     sr_i;
            logic [PHASE_BITS-1:0] sq_i;
            div_t                  rs;
            div_t                  ss;
            if (g == 0)
            begin : g_first
                assign rn_i = rn_in;
                assign rr_i = '0;
                assign rq_i = '0;
                assign sn_i = sn_in;
                assign sr_i = '0;
                assign sq_i = '0;
            end
            else
            begin : g_next
                assign rn_i = rn_reg[g-1];
                assign rr_i = rr_reg[g-1];
                assign rq_i = rq_reg[g-1];
                assign sn_i = sn_reg[g-1];
                assign sr_i = sr_reg[g-1];
                assign sq_i = sq_reg[g-1];
            end
            assign rs = div_step(rr_i, rn_i[DIV_W-1-g], rdiv);
            assign ss = div_step(sr_i, sn_i[DIV_W-1-g], sdiv);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rn_reg[g] <= rn_i;
                    rr_reg[g] <= rs.rem;
                    rq_reg[g] <= {rq_i[PHASE_BITS-2:0], rs.q};
                    sn_reg[g] <= sn_i;
                    sr_reg[g] <= ss.rem;
                    sq_reg[g] <= {sq_i[PHASE_BITS-2:0], ss.q};
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rfold_reg <= fold(rq_reg[DIV_W-1]);
            sfold_reg <= fold(sq_reg[DIV_W-1]);
        end
    end

    // CORDIC rotation, one micro-rotation per stage
    generate
        for (g = 0; g < CORDIC_STEPS; g++)
        begin : g_cordic
            cordic_t rc_i;
            cordic_t sc_i;
            logic    rf_i;
            logic    sf_i;
            if (g == 0)
            begin : g_first
                assign rc_i = '{x: CW'(CORDIC_START), y: '0, z: rfold_reg.z};
                assign sc_i = '{x: CW'(CORDIC_START), y: '0, z: sfold_reg.z};
                assign rf_i = rfold_reg.flip;
                assign sf_i = sfold_reg.flip;
            end
            else
            begin : g_next
                assign rc_i = rc_reg[g-1];
                assign sc_i = sc_reg[g-1];
                assign rf_i = rflip_reg[g-1];
                assign sf_i = sflip_reg[g-1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rc_reg[g]    <= cordic_step(rc_i, g);
                    sc_reg[g]    <= cordic_step(sc_i, g);
                    rflip_reg[g] <= rf_i;
                    sflip_reg[g] <= sf_i;
                end
            end
        end
    endgenerate

    // clamp, then the two multiplier stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_r_reg  <= finish_q15(rc_reg[CORDIC_STEPS-1].y, rflip_reg[CORDIC_STEPS-1]);
            cos_r_reg  <= finish_q15(rc_reg[CORDIC_STEPS-1].x, rflip_reg[CORDIC_STEPS-1]);
            sin_s_reg  <= finish_q15(sc_reg[CORDIC_STEPS-1].y, sflip_reg[CORDIC_STEPS-1]);
            cos_s_reg  <= finish_q15(sc_reg[CORDIC_STEPS-1].x, sflip_reg[CORDIC_STEPS-1]);

            r0_reg     <= $signed({1'b0, radius_reg}) * sin_r_reg;
            ycr_reg    <= $signed({1'b0, radius_reg}) * cos_r_reg;
            sin_s1_reg <= sin_s_reg;
            cos_s1_reg <= cos_s_reg;

            px_reg     <= r0_reg * sin_s1_reg;
            pz_reg     <= r0_reg * cos_s1_reg;
            ycr2_reg   <= ycr_reg;
        end
    end

    // output stage: round half up, saturate, build indices
    logic [COUNT_BITS-1:0]   o_ring;
    logic [COUNT_BITS-1:0]   o_seg;
    logic [2*COUNT_BITS+1:0] o_v;
    logic [INDEX_BITS-1:0]   i_v;
    logic [INDEX_BITS-1:0]   i_vs;
    logic [INDEX_BITS-1:0]   i_vs1;
    logic [INDEX_BITS-1:0]   i_v1;
    logic                    o_valid;
    logic                    o_bad;
    logic signed [49:0]      rx;
    logic signed [49:0]      ry;
    logic signed [49:0]      rz;

    always_comb
    begin
        o_ring  = tag_reg[NST-2][COUNT_BITS-1:0];
        o_seg   = tag_reg[NST-2][TAG_W-1:COUNT_BITS];
        o_v     = (2*COUNT_BITS+2)'(o_ring) * (2*COUNT_BITS+2)'({1'b0, segs_reg} + 9'd1)
                  + (2*COUNT_BITS+2)'(o_seg);
        i_v     = INDEX_BITS'(o_v);
        i_vs    = INDEX_BITS'(o_v + (2*COUNT_BITS+2)'(segs_reg));
        i_vs1   = INDEX_BITS'(o_v + (2*COUNT_BITS+2)'(segs_reg) + 1'b1);
        i_v1    = INDEX_BITS'(o_v + 1'b1);
        o_valid = o_ring < rings_reg;
        o_bad   = (o_ring > rings_reg) || (o_seg > segs_reg);
        rx      = (50'(px_reg) + (50'sd1 <<< 29)) >>> 30;
        rz      = (50'(pz_reg) + (50'sd1 <<< 29)) >>> 30;
        ry      = (50'(ycr2_reg) + (50'sd1 <<< 14)) >>> 15;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg[15:0]  <= sat_coord(rx);
            data_reg[31:16] <= sat_coord(ry);
            data_reg[47:32] <= sat_coord(rz);
            if (o_valid)
            begin
                data_reg[63:48]   <= i_vs1;
                data_reg[79:64]   <= i_v;
                data_reg[95:80]   <= i_vs;
                data_reg[111:96]  <= i_vs1;
                data_reg[127:112] <= i_v1;
                data_reg[143:128] <= i_v;
            end
            else
            begin
                data_reg[143:48] <= '0;
            end
            user_reg <= {o_bad, o_valid};
        end
    end

endmodule

`default_nettype wire
